### hw/rtl/bsil_pkg.sv
package bsil_pkg;

  // List depth
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int TAG_W  = 32;
  localparam int RPOS_W = 4;
  localparam int OUT_W  = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [TAG_W-1:0]        item_tag;
    logic signed [KEY_W-1:0] item_key;
    logic [RPOS_W-1:0]       read_position;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]        entry_count;
    logic [OUT_W-1:0]        placed_position;
    logic [TAG_W-1:0]        read_tag;
    logic signed [KEY_W-1:0] read_key;
    logic                    read_valid;
  } out_item_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic ins_en;
    logic ascending;
  } cell_ctrl_t;

endpackage

### hw/rtl/bsil_ifs.sv
interface bsil_in_if;
  import bsil_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsil_out_if;
  import bsil_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bsil_cell.sv
module bsil_cell (
  input  logic                              clk,
  input  bsil_pkg::cell_ctrl_t              ctrl,
  input  logic                              active,
  input  logic signed [bsil_pkg::KEY_W-1:0] new_key,
  input  logic [bsil_pkg::TAG_W-1:0]        new_tag,
  input  logic                              left_take,
  input  logic signed [bsil_pkg::KEY_W-1:0] left_key,
  input  logic [bsil_pkg::TAG_W-1:0]        left_tag,
  input  logic                              take,
  output logic                              bid,
  output logic signed [bsil_pkg::KEY_W-1:0] key_r,
  output logic [bsil_pkg::TAG_W-1:0]        tag_r
);
  import bsil_pkg::*;

  logic                    ahead;
  logic signed [KEY_W-1:0] key_nxt;
  logic [TAG_W-1:0]        tag_nxt;

  // New key sorts strictly ahead of this entry; ties stay behind
  assign ahead = ctrl.ascending ? (new_key < key_r) : (new_key > key_r);
  // Empty cells always bid: the first one becomes the append slot
  assign bid = !active || ahead;

  // Keep, load the new pair at the boundary, or shift in from the left
  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.ins_en && take) begin
      if (left_take) begin
        key_nxt = left_key;
        tag_nxt = left_tag;
      end else begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

endmodule

### hw/rtl/bounded_sorted_insert_list.sv
// An accepted transaction's result is written to the output register in the next cycle.
// Throughput: 1 transaction per cycle if in ready; cells compare in parallel, shift in one step.
// A new transaction is taken while the held result is being taken (in ready = empty or out ready).
// Reset (rst_n low, synchronous): list count cleared, order set to ascending, output empty.
// Cell contents are not reset; cells beyond the count are never read.
module bounded_sorted_insert_list (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  bsil_in_if.sink       in_ch,
  bsil_out_if.source    out_ch
);
  import bsil_pkg::*;

  logic                    asc_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r;
  out_item_t               out_r, out_nxt;
  logic                    accept;
  logic                    ins_acc;
  cell_ctrl_t              ctrl;

  logic [CAPACITY-1:0]     bid_vec;
  logic [CAPACITY-1:0]     take_vec;
  logic [CAPACITY-1:0]     active_vec;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [TAG_W-1:0]        cell_tag [CAPACITY];

  logic [OUT_W-1:0]        placed;
  logic                    rd_hit;
  logic signed [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0]        rd_tag;

  // Handshake
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign ins_acc      = accept && (in_ch.data.operation == OP_INSERT);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign ctrl.ins_en    = ins_acc;
  assign ctrl.ascending = asc_r;

  // Row of compare-and-shift cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign active_vec[i] = (CNT_W'(i) < cnt_r);
    if (i == 0) begin : g_head
      bsil_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .active    (active_vec[i]),
        .new_key   (in_ch.data.item_key),
        .new_tag   (in_ch.data.item_tag),
        .left_take (1'b0),
        .left_key  (in_ch.data.item_key),
        .left_tag  (in_ch.data.item_tag),
        .take      (take_vec[i]),
        .bid       (bid_vec[i]),
        .key_r     (cell_key[i]),
        .tag_r     (cell_tag[i])
      );
    end else begin : g_body
      bsil_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .active    (active_vec[i]),
        .new_key   (in_ch.data.item_key),
        .new_tag   (in_ch.data.item_tag),
        .left_take (take_vec[i-1]),
        .left_key  (cell_key[i-1]),
        .left_tag  (cell_tag[i-1]),
        .take      (take_vec[i]),
        .bid       (bid_vec[i]),
        .key_r     (cell_key[i]),
        .tag_r     (cell_tag[i])
      );
    end
  end

  // A cell takes only if every cell behind it bids too: the scan runs back from the tail,
  // so an entry out of the current order stops it
  always_comb begin
    logic run;
    run = 1'b1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      run         = run & bid_vec[i];
      take_vec[i] = run;
    end
  end

  // Landing place: cells that keep their entry form a prefix
  assign placed = OUT_W'($countones(~take_vec));

  // Read select
  always_comb begin
    rd_key = '0;
    rd_tag = '0;
    rd_hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((in_ch.data.read_position == RPOS_W'(i)) && active_vec[i]) begin
        rd_key = cell_key[i];
        rd_tag = cell_tag[i];
        rd_hit = 1'b1;
      end
    end
  end

  // Count and result
  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_acc && (cnt_r < CNT_W'(CAPACITY))) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    out_nxt.entry_count     = OUT_W'(cnt_nxt);
    out_nxt.placed_position = '0;
    out_nxt.read_tag        = '0;
    out_nxt.read_key        = '0;
    out_nxt.read_valid      = 1'b0;
    case (in_ch.data.operation)
      OP_INSERT: begin
        out_nxt.placed_position = placed;
      end
      OP_READ: begin
        out_nxt.read_tag   = rd_tag;
        out_nxt.read_key   = rd_key;
        out_nxt.read_valid = rd_hit;
      end
      default: begin
        out_nxt.placed_position = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asc_r       <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        asc_r <= cfg_wr_data;
      end
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  // Count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Insert boundary: take flags are a kept prefix then a taking suffix
  a_take_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take_vec & ~{take_vec[CAPACITY-2:0], 1'b0}))
    else $error("take flags not monotone");

  // Insert into a list with room grows the count by one
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_acc && (cnt_r < CNT_W'(CAPACITY))) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("count did not grow on insert");

  // Every accepted transaction leaves a result behind
  a_out_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("result missing after accepted transaction");

endmodule
